// ===== hw/rtl/obdc_pkg.sv =====
// Package: shared types, codes and reset constants of the one-button dimmer control.
`default_nettype none
package obdc_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned LEVEL_W  = 8;
	localparam int unsigned WINDOW_W = 16;
	localparam int unsigned REQ_W    = 3;
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_RECENT_WINDOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIM_STEP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MAX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MOVE_RATE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL   = 3'd5;

	// reset values
	localparam logic [WINDOW_W-1:0] RECENT_WINDOW_RST = 16'd1500;
	localparam logic [LEVEL_W-1:0]  DIM_STEP_RST      = 8'd4;
	localparam logic [LEVEL_W-1:0]  LEVEL_MIN_RST     = 8'd1;
	localparam logic [LEVEL_W-1:0]  LEVEL_MAX_RST     = 8'd254;
	localparam logic [LEVEL_W-1:0]  MOVE_RATE_RST     = 8'd42;
	localparam logic [LEVEL_W-1:0]  START_LEVEL_RST   = 8'd254;

	typedef enum logic [REQ_W-1:0] {
		REQ_PRESS     = 3'd0,
		REQ_CLICK     = 3'd1,
		REQ_HOLD      = 3'd2,
		REQ_RELEASE   = 3'd3,
		REQ_TICK      = 3'd4,
		REQ_SET_ONOFF = 3'd5,
		REQ_SET_LEVEL = 3'd6
	} req_code_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE   = 2'd0,
		CMD_TOGGLE = 2'd1,
		CMD_MOVE   = 2'd2,
		CMD_STOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef struct packed {
		logic [WINDOW_W-1:0] recent_window_ms;
		logic [LEVEL_W-1:0]  dim_step;
		logic [LEVEL_W-1:0]  level_min;
		logic [LEVEL_W-1:0]  level_max;
		logic [LEVEL_W-1:0]  move_rate;
	} cfg_t;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [TIME_W-1:0]  now_ms;
		logic [LEVEL_W-1:0] write_value;
	} req_item_t;

	typedef struct packed {
		logic               light_on;
		logic [LEVEL_W-1:0] level;
		dir_t               direction;
		logic [TIME_W-1:0]  last_click_ms;
		logic               hold_active;
		logic               ticking;
	} dim_state_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] led_level;
		cmd_t               command;
		logic               move_down;
		logic [LEVEL_W-1:0] move_rate_out;
		logic               is_on;
		logic [LEVEL_W-1:0] level_now;
	} result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/obdc_if.sv =====
// Interfaces: request, result and configuration channels of the dimmer control.
`default_nettype none
interface obdc_req_if;
	import obdc_pkg::*;
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [TIME_W-1:0]  now_ms;
	logic [LEVEL_W-1:0] write_value;
	modport source (output valid, req_type, now_ms, write_value, input ready);
	modport sink   (input valid, req_type, now_ms, write_value, output ready);
endinterface

interface obdc_res_if;
	import obdc_pkg::*;
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] led_level;
	logic [CMD_W-1:0]   command;
	logic               move_down;
	logic [LEVEL_W-1:0] move_rate_out;
	logic               is_on;
	logic [LEVEL_W-1:0] level_now;
	modport source (output valid, led_level, command, move_down, move_rate_out, is_on,
		level_now, input ready);
	modport sink   (input valid, led_level, command, move_down, move_rate_out, is_on,
		level_now, output ready);
endinterface

interface obdc_cfg_if;
	import obdc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/obdc_cfg_regs.sv =====
// Configuration register file of the dimmer control.
`default_nettype none
module obdc_cfg_regs (
	input  wire logic     clk,
	input  wire logic     arst_n,
	obdc_cfg_if.sink      cfg,
	output obdc_pkg::cfg_t cfg_q
);
	import obdc_pkg::*;

	logic wr;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid && cfg.ready;

	// start level only matters at reset, so its write is taken and dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.recent_window_ms <= RECENT_WINDOW_RST;
			cfg_q.dim_step         <= DIM_STEP_RST;
			cfg_q.level_min        <= LEVEL_MIN_RST;
			cfg_q.level_max        <= LEVEL_MAX_RST;
			cfg_q.move_rate        <= MOVE_RATE_RST;
		end else if (wr) begin
			case (cfg.index)
				CFG_RECENT_WINDOW: cfg_q.recent_window_ms <= cfg.data;
				CFG_DIM_STEP:      cfg_q.dim_step  <= cfg.data[LEVEL_W-1:0];
				CFG_LEVEL_MIN:     cfg_q.level_min <= cfg.data[LEVEL_W-1:0];
				CFG_LEVEL_MAX:     cfg_q.level_max <= cfg.data[LEVEL_W-1:0];
				CFG_MOVE_RATE:     cfg_q.move_rate <= cfg.data[LEVEL_W-1:0];
				CFG_START_LEVEL:   ;
				default:           ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/obdc_step.sv =====
// Next-state and result logic for one request of the dimmer control.
`default_nettype none
module obdc_step (
	input  wire obdc_pkg::cfg_t       cfg,
	input  wire obdc_pkg::req_item_t  item,
	input  wire obdc_pkg::dim_state_t cur,
	output obdc_pkg::dim_state_t nxt,
	output obdc_pkg::result_t    res
);
	import obdc_pkg::*;

	logic [TIME_W-1:0]      gap;
	logic                   recent;
	logic signed [LEVEL_W+1:0] lvl_ext;
	logic signed [LEVEL_W+1:0] step_ext;
	logic signed [LEVEL_W+1:0] max_ext;
	logic signed [LEVEL_W+1:0] min_ext;
	logic signed [LEVEL_W+1:0] moved;
	logic signed [LEVEL_W+1:0] clamp_hi;
	logic signed [LEVEL_W+1:0] clamped;

	assign gap    = item.now_ms - cur.last_click_ms;
	assign recent = gap < {{(TIME_W-WINDOW_W){1'b0}}, cfg.recent_window_ms};

	assign lvl_ext  = {2'b00, cur.level};
	assign step_ext = {2'b00, cfg.dim_step};
	assign max_ext  = {2'b00, cfg.level_max};
	assign min_ext  = {2'b00, cfg.level_min};

	always_comb begin
		case (cur.direction)
			DIR_UP:   moved = lvl_ext + step_ext;
			DIR_DOWN: moved = lvl_ext - step_ext;
			default:  moved = lvl_ext;
		endcase
	end

	// upper bound first, then lower: a crossed pair ends at the minimum
	assign clamp_hi = (moved > max_ext) ? max_ext : moved;
	assign clamped  = (clamp_hi < min_ext) ? min_ext : clamp_hi;

	always_comb begin
		nxt               = cur;
		res.command       = CMD_NONE;
		res.move_down     = 1'b0;
		res.move_rate_out = '0;
		case (item.req_type)
			REQ_PRESS: begin
				nxt.direction = recent ? DIR_DOWN : DIR_UP;
			end
			REQ_CLICK: begin
				nxt.last_click_ms = item.now_ms;
				nxt.light_on      = !cur.light_on;
				res.command       = CMD_TOGGLE;
			end
			REQ_HOLD: begin
				nxt.hold_active   = 1'b1;
				nxt.ticking       = 1'b1;
				res.command       = CMD_MOVE;
				res.move_down     = (cur.direction == DIR_DOWN);
				res.move_rate_out = cfg.move_rate;
			end
			REQ_RELEASE: begin
				nxt.ticking = 1'b0;
				if (cur.hold_active) begin
					nxt.hold_active = 1'b0;
					res.command     = CMD_STOP;
				end
			end
			REQ_TICK: begin
				if (cur.ticking) begin
					nxt.level = clamped[LEVEL_W-1:0];
					if (clamped == max_ext || clamped == min_ext) begin
						nxt.ticking = 1'b0;
					end
				end
			end
			REQ_SET_ONOFF: begin
				nxt.light_on = item.write_value[0];
			end
			REQ_SET_LEVEL: begin
				nxt.level = item.write_value;
			end
			default: ;
		endcase
		res.is_on     = nxt.light_on;
		res.level_now = nxt.level;
		res.led_level = nxt.light_on ? nxt.level : '0;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/one_button_dimmer_control.sv =====
// Top level of the one-button dimmer control: channels, state and result registers.
//
// Usage
//   req : button events, ticks and external writes (req_type, now_ms, write_value).
//         A request is taken at a clock edge with req.valid and req.ready high.
//   res : exactly one result per request, in order (LED level, command, move
//         mode and rate, on/off and level after the request).
//   cfg : register writes (index, data), always ready; write only while idle.
// Timing
//   A request is held in the input register, processed by the step logic
//   against the light state and lands in the result register, from which
//   it shows on res. One request per cycle is sustained while res is not
//   stalled; the state update and result share that single register stage.
// Stall
//   While res is stalled the input register may still fill, so one extra
//   request is buffered; req.ready then drops until the result is taken.
// Reset
//   arst_n clears both stages, the light goes off at level 254, dimming stops
//   and the registers take their default values.
`default_nettype none
module one_button_dimmer_control (
	input  wire logic clk,
	input  wire logic arst_n,
	obdc_req_if.sink   req,
	obdc_res_if.source res,
	obdc_cfg_if.sink   cfg
);
	import obdc_pkg::*;

	cfg_t       cfg_q;
	req_item_t  item_s1;
	logic       vld_s1;
	dim_state_t state_q;
	dim_state_t state_nxt;
	result_t    step_res;
	result_t    res_q;
	logic       res_vld_q;
	logic       out_free;
	logic       advance;

	obdc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	obdc_step u_step (
		.cfg  (cfg_q),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (step_res)
	);

	// result register frees up when empty or taken this cycle
	assign out_free  = !res_vld_q || res.ready;
	assign advance   = vld_s1 && out_free;
	assign req.ready = !vld_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type    <= req.req_type;
			item_s1.now_ms      <= req.now_ms;
			item_s1.write_value <= req.write_value;
		end
	end

	// light state moves only as a request passes into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.light_on      <= 1'b0;
			state_q.level         <= START_LEVEL_RST;
			state_q.direction     <= DIR_NONE;
			state_q.last_click_ms <= '0;
			state_q.hold_active   <= 1'b0;
			state_q.ticking       <= 1'b0;
			res_vld_q             <= 1'b0;
		end else if (advance) begin
			state_q   <= state_nxt;
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign res.valid         = res_vld_q;
	assign res.led_level     = res_q.led_level;
	assign res.command       = res_q.command;
	assign res.move_down     = res_q.move_down;
	assign res.move_rate_out = res_q.move_rate_out;
	assign res.is_on         = res_q.is_on;
	assign res.level_now     = res_q.level_now;

	// ticking is only ever started by a hold and both end on release
	a_tick_needs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.ticking |-> state_q.hold_active)
		else $error("dimming active without a hold");

	a_led_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && !res_q.is_on |-> res_q.led_level == '0)
		else $error("LED lit while off");

	a_led_on: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_q.is_on |-> res_q.led_level == res_q.level_now)
		else $error("LED level differs from level while on");

	a_move_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_q.command != CMD_MOVE |->
			!res_q.move_down && res_q.move_rate_out == '0)
		else $error("move fields set without a move command");

endmodule
`default_nettype wire

// ===== test/one_button_dimmer_control_test.sv =====
`timescale 1ns / 100ps
// Testbench of the one-button dimmer control: directed and random requests checked against a predictor.
module one_button_dimmer_control_test;
	import obdc_pkg::*;

	// request code with no meaning: block must leave state alone and answer with no command
	localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
	localparam int unsigned REPORT_MAX       = 10;
	localparam int unsigned RANDOM_PER_PHASE = 240;
	localparam int unsigned SETTING_COUNT    = 6;
	localparam longint      LIMIT_NS         = 5_000_000;

	// Light-state predictor: tracks state and registers, queues the answer each request earns.
	class dimmer_tracker;
		bit [31:0] window_ms;
		int        step, level_min, level_max, rate, start_level;
		bit        light_on, hold_active, ticking;
		int        level;
		dir_t      direction;
		bit [31:0] last_click_ms;
		result_t   expected_results[$];
		int unsigned mismatches;
		int unsigned checked;

		function new();
			window_ms     = RECENT_WINDOW_RST;
			step          = DIM_STEP_RST;
			level_min     = LEVEL_MIN_RST;
			level_max     = LEVEL_MAX_RST;
			rate          = MOVE_RATE_RST;
			start_level   = START_LEVEL_RST;
			light_on      = 1'b0;
			level         = start_level;
			direction     = DIR_NONE;
			last_click_ms = '0;
			hold_active   = 1'b0;
			ticking       = 1'b0;
			mismatches    = 0;
			checked       = 0;
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		function void take_register_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_RECENT_WINDOW: window_ms   = data;
				CFG_DIM_STEP:      step        = data[7:0];
				CFG_LEVEL_MIN:     level_min   = data[7:0];
				CFG_LEVEL_MAX:     level_max   = data[7:0];
				CFG_MOVE_RATE:     rate        = data[7:0];
				CFG_START_LEVEL:   start_level = data[7:0];
				default: ;
			endcase
		endfunction

		function void take_request(req_item_t item);
			result_t   want;
			bit [31:0] since_click;
			int        stepped;
			want = '0;
			want.command = CMD_NONE;
			case (item.req_type)
				REQ_PRESS: begin
					since_click = item.now_ms - last_click_ms;
					direction = (since_click < window_ms) ? DIR_DOWN : DIR_UP;
				end
				REQ_CLICK: begin
					last_click_ms = item.now_ms;
					light_on = !light_on;
					want.command = CMD_TOGGLE;
				end
				REQ_HOLD: begin
					hold_active = 1'b1;
					ticking = 1'b1;
					want.command = CMD_MOVE;
					want.move_down = (direction == DIR_DOWN);
					want.move_rate_out = rate[7:0];
				end
				REQ_RELEASE: begin
					ticking = 1'b0;
					if (hold_active) begin
						hold_active = 1'b0;
						want.command = CMD_STOP;
					end
				end
				REQ_TICK: begin
					if (ticking) begin
						stepped = level;
						if (direction == DIR_UP)
							stepped += step;
						else if (direction == DIR_DOWN)
							stepped -= step;
						// max clamp first, so an inverted range lands on level_min
						if (stepped > level_max)
							stepped = level_max;
						if (stepped < level_min)
							stepped = level_min;
						level = stepped & 255;
						if (stepped == level_max || stepped == level_min)
							ticking = 1'b0;
					end
				end
				REQ_SET_ONOFF: light_on = item.write_value[0];
				REQ_SET_LEVEL: level = item.write_value;
				default: ;
			endcase
			want.led_level = light_on ? level[7:0] : '0;
			want.is_on     = light_on;
			want.level_now = level[7:0];
			expected_results.push_back(want);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: result with nothing outstanding: led %0d cmd %0d level %0d",
						$realtime, got.led_level, got.command, got.level_now);
				return;
			end
			want = expected_results.pop_front();
			if (got.led_level !== want.led_level || got.command !== want.command ||
					got.move_down !== want.move_down || got.move_rate_out !== want.move_rate_out ||
					got.is_on !== want.is_on || got.level_now !== want.level_now) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: result %0d (expected/actual) led %0d/%0d cmd %0d/%0d ",
						$realtime, checked,
						want.led_level, got.led_level, want.command, got.command,
						"down %0b/%0b rate %0d/%0d on %0b/%0b level %0d/%0d",
						want.move_down, got.move_down, want.move_rate_out, got.move_rate_out,
						want.is_on, got.is_on, want.level_now, got.level_now);
			end
			checked++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	obdc_req_if req_ch();
	obdc_res_if res_ch();
	obdc_cfg_if cfg_ch();

	one_button_dimmer_control u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	dimmer_tracker tracker = new();

	// stimulus store and generator state
	req_item_t request_q[$];
	bit [31:0] clock_ms;       // running button time
	bit [31:0] last_click_gen; // time of the latest click generated
	bit [31:0] cur_window;     // window as last programmed, to aim press gaps at it

	// receiver stall pattern
	int stall_mode = 0;
	int stall_left = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#(LIMIT_NS);
		$display("Regression FAIL");
		$finish;
	end

	// Result side: stall behaviour changes after a stretch of random length; mode 0 is a clean stretch.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(50, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       res_ch.ready <= 1'b1;
			1:       res_ch.ready <= 1'($urandom_range(0, 1));
			2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
			default: res_ch.ready <= (stall_left % 3) != 0;
		endcase
	end

	// Every handshake is observed here at the rising edge: requests feed the predictor,
	// register writes update its copy of the registers, results are checked in order.
	always @(posedge clk) begin : watch
		req_item_t taken;
		result_t   got;
		if (arst_n === 1'b1) begin
			if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
				tracker.take_register_write(cfg_ch.index, cfg_ch.data);
			if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
				taken.req_type    = req_ch.req_type;
				taken.now_ms      = req_ch.now_ms;
				taken.write_value = req_ch.write_value;
				tracker.take_request(taken);
			end
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				got.led_level     = res_ch.led_level;
				got.command       = cmd_t'(res_ch.command);
				got.move_down     = res_ch.move_down;
				got.move_rate_out = res_ch.move_rate_out;
				got.is_on         = res_ch.is_on;
				got.level_now     = res_ch.level_now;
				tracker.check_result(got);
			end
		end
	end

	task automatic add_request(logic [REQ_W-1:0] code, bit [31:0] now, bit [7:0] wval);
		req_item_t item;
		item.req_type    = code;
		item.now_ms      = now;
		item.write_value = wval;
		request_q.push_back(item);
		clock_ms = now;
		if (code == REQ_CLICK)
			last_click_gen = now;
	endtask

	// Random writes and click, then press/hold/ticks/release; press gaps below, at and past the window.
	task automatic make_gesture();
		bit [31:0] gap;
		int        ticks;
		if ($urandom_range(0, 3) == 0)
			add_request(REQ_SET_ONOFF, clock_ms, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 3) == 0)
			add_request(REQ_SET_LEVEL, clock_ms + 5, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 2) != 0)
			add_request(REQ_CLICK, clock_ms + $urandom_range(1, 3000), 8'($urandom));
		case ($urandom_range(0, 3))
			0:       gap = (cur_window == 0) ? 32'd0 : $urandom_range(0, cur_window - 1);
			1:       gap = cur_window + $urandom_range(0, 2) - 1;
			2:       gap = $urandom_range(0, 200000);
			default: gap = $urandom;
		endcase
		add_request(REQ_PRESS, last_click_gen + gap, 8'($urandom));
		add_request(REQ_HOLD, clock_ms + $urandom_range(300, 900), 8'($urandom));
		ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 20);
		repeat (ticks)
			add_request(REQ_TICK, clock_ms + 100, 8'($urandom));
		// now and then the release goes missing, leaving the hold open
		if ($urandom_range(0, 9) != 0)
			add_request(REQ_RELEASE, clock_ms + $urandom_range(0, 50), 8'($urandom));
	endtask

	task automatic make_noise();
		bit [31:0] now;
		now = ($urandom_range(0, 3) == 0) ? $urandom : clock_ms + $urandom_range(0, 5000);
		case ($urandom_range(0, 3))
			0:       add_request(REQ_SET_LEVEL, now, 8'($urandom_range(0, 255)));
			1:       add_request(REQ_SET_ONOFF, now, 8'($urandom_range(0, 255)));
			default: add_request(3'($urandom_range(0, 7)), now, 8'($urandom_range(0, 255)));
		endcase
	endtask

	// Sender: bursts of random length, valid held high within a burst, random gaps between.
	task automatic play_requests();
		req_item_t item;
		int        burst;
		while (request_q.size() > 0) begin
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
			while (burst > 0 && request_q.size() > 0) begin
				item = request_q.pop_front();
				@(negedge clk);
				req_ch.valid       <= 1'b1;
				req_ch.req_type    <= item.req_type;
				req_ch.now_ms      <= item.now_ms;
				req_ch.write_value <= item.write_value;
				do @(posedge clk); while (req_ch.ready !== 1'b1);
				burst--;
			end
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
	endtask

	task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// 8-bit registers get junk in the upper data byte; only the low byte should count
	task automatic apply_settings(bit [15:0] window, bit [7:0] step, bit [7:0] lmin,
			bit [7:0] lmax, bit [7:0] rate, bit [7:0] start);
		set_register(CFG_RECENT_WINDOW, window);
		set_register(CFG_DIM_STEP,      {8'($urandom), step});
		set_register(CFG_LEVEL_MIN,     {8'($urandom), lmin});
		set_register(CFG_LEVEL_MAX,     {8'($urandom), lmax});
		set_register(CFG_MOVE_RATE,     {8'($urandom), rate});
		set_register(CFG_START_LEVEL,   {8'($urandom), start});
		cur_window = window;
	endtask

	// All results in, then a short pause.
	task automatic wait_drained();
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = REQ_PRESS;
		req_ch.now_ms      = '0;
		req_ch.write_value = '0;
		res_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = CFG_RECENT_WINDOW;
		cfg_ch.data        = '0;
		clock_ms           = '0;
		last_click_gen     = '0;
		cur_window         = RECENT_WINDOW_RST;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed requests on reset settings.
		add_request(REQ_TICK,      32'h0000_0000, 8'h00); // tick with dimming stopped
		add_request(REQ_RELEASE,   32'h0000_0010, 8'hFF); // release with no hold
		add_request(REQ_HOLD,      32'h0000_0020, 8'h00); // hold before any press: mode up
		add_request(REQ_TICK,      32'h0000_0030, 8'h00); // no direction: clamp only, stops at max
		add_request(REQ_TICK,      32'h0000_0040, 8'h00);
		add_request(REQ_RELEASE,   32'h0000_0050, 8'h00); // stop request
		add_request(REQ_SET_ONOFF, 32'h0000_0060, 8'hFE); // bit 0 clear: off
		add_request(REQ_SET_ONOFF, 32'h0000_0070, 8'h01);
		add_request(REQ_SET_LEVEL, 32'h0000_0080, 8'hFF);
		add_request(REQ_SET_LEVEL, 32'h0000_0090, 8'h00);
		add_request(REQ_CLICK,     32'hFFFF_FF00, 8'h00);
		add_request(REQ_PRESS,     32'h0000_0100, 8'h00); // gap wraps through zero: dim down
		add_request(REQ_HOLD,      32'h0000_0200, 8'h00);
		add_request(REQ_TICK,      32'h0000_0300, 8'h00); // below zero, clamps to min
		add_request(REQ_RELEASE,   32'h0000_0310, 8'h00);
		add_request(REQ_CLICK,     32'hFFFF_FFFF, 8'hFF);
		add_request(REQ_PRESS,     32'h0000_05DB, 8'h00); // gap equals window: dim up
		add_request(REQ_SET_LEVEL, 32'h0000_05E0, 8'd100);
		add_request(REQ_HOLD,      32'h0000_0600, 8'h00);
		add_request(REQ_TICK,      32'h0000_0700, 8'h00);
		add_request(REQ_TICK,      32'h0000_0800, 8'h00);
		add_request(REQ_UNUSED,    32'h0000_0900, 8'hFF);
		add_request(REQ_RELEASE,   32'h0000_0A00, 8'h00);
		add_request(REQ_PRESS,     32'h0000_05DA, 8'h00); // one below window: dim down
		add_request(REQ_SET_LEVEL, 32'hFFFF_FFFF, 8'h00);
		play_requests();

		for (int phase = 0; phase < SETTING_COUNT; phase++) begin
			wait_drained();
			case (phase)
				0: apply_settings(16'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0);
				1: apply_settings(16'hFFFF, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255);
				// inverted range: min above max
				2: apply_settings(16'($urandom), 8'd1, 8'd200, 8'd50, 8'($urandom), 8'($urandom));
				3: apply_settings(16'd300, 8'd7, 8'd10, 8'd240, 8'd100, 8'd128);
				4: apply_settings(16'($urandom_range(0, 5000)), 8'($urandom_range(0, 40)),
					8'($urandom_range(0, 60)), 8'($urandom_range(180, 255)),
					8'($urandom), 8'($urandom));
				default: apply_settings(RECENT_WINDOW_RST, DIM_STEP_RST, LEVEL_MIN_RST,
					LEVEL_MAX_RST, MOVE_RATE_RST, START_LEVEL_RST);
			endcase
			while (request_q.size() < RANDOM_PER_PHASE) begin
				if ($urandom_range(0, 3) != 0)
					make_gesture();
				else
					make_noise();
			end
			play_requests();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
